// ===== sv/sthr_pkg.sv =====
// shared types, mode codes and command codes of the steiner tree unit
package sthr_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  from_node;
        logic [2:0]  to_node;
        logic [15:0] link_weight;
    } sthr_item_t;

    typedef struct packed {
        logic [2:0]  path_index;
        logic [2:0]  node;
        logic [18:0] path_cost;
        logic        end_of_path;
        logic        last;
        logic        status;
    } sthr_result_t;

    localparam logic [1:0] MODE_LINK  = 2'd0;
    localparam logic [1:0] MODE_DEST  = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam int          COST_BITS = 19;
    localparam logic [18:0] COST_MAX  = 19'h7FFFF;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_UNRCH = 1'b1;

    localparam logic [4:0] OP_NONE        = 5'd0;
    localparam logic [4:0] OP_ACCEPT      = 5'd1;
    localparam logic [4:0] OP_DEST        = 5'd2;
    localparam logic [4:0] OP_CLEAR       = 5'd3;
    localparam logic [4:0] OP_LD_RD       = 5'd4;
    localparam logic [4:0] OP_LD_WR       = 5'd5;
    localparam logic [4:0] OP_RUN_INIT    = 5'd6;
    localparam logic [4:0] OP_ROUND_START = 5'd7;
    localparam logic [4:0] OP_EMIT_INSIDE = 5'd8;
    localparam logic [4:0] OP_T_NEXT      = 5'd9;
    localparam logic [4:0] OP_SRCH_INIT   = 5'd10;
    localparam logic [4:0] OP_SEL_STEP    = 5'd11;
    localparam logic [4:0] OP_SETTLE      = 5'd12;
    localparam logic [4:0] OP_RLX_STEP    = 5'd13;
    localparam logic [4:0] OP_DST_START   = 5'd14;
    localparam logic [4:0] OP_DST_SKIP    = 5'd15;
    localparam logic [4:0] OP_DST_TAKE    = 5'd16;
    localparam logic [4:0] OP_TRACE_STEP  = 5'd17;
    localparam logic [4:0] OP_PATH_START  = 5'd18;
    localparam logic [4:0] OP_EMIT_PATH   = 5'd19;
    localparam logic [4:0] OP_EMIT_ERR    = 5'd20;
    localparam logic [4:0] OP_SRC_ERR     = 5'd21;

    typedef struct packed {
        logic [4:0] op;
    } sthr_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       src_ok;
        logic       rem_zero;
        logic       inside_nz;
        logic       t_end;
        logic       t_in_tree;
        logic       cnt_end;
        logic       cnt_last;
        logic       have;
        logic       cand;
        logic       trace_stop;
        logic       found;
        logic       ecnt_one;
        logic       out_free;
    } sthr_stat_t;

endpackage

// ===== sv/sthr_stream_if.sv =====
// valid/ready stream interface carrying one payload
interface sthr_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/steiner_tree_shortest_path_heuristic_unit.sv =====
// top level of the shortest-path heuristic multicast tree builder
// The unit holds a directed graph of NODE_COUNT nodes in a link memory
// (one entry per node pair, valid bits in flops, so reset and the clear mode
// empty it at once) plus a destination set. A link load reads the stored
// weight before it writes; a destination add or a clear acts at dispatch.
// A run grows a tree from the source: each round emits a destination already
// on the tree at zero cost, else runs one shortest-path search from every tree
// node and joins the cheapest unserved destination. One search is a serial
// sequence: for each settled node a selection scan over all nodes and a
// relaxation with one link-memory read per neighbor, then a destination scan;
// up to N searches per round and N rounds. Results leave through a single
// output register; a stalled output holds the sequencer only when a new
// result is due. The next input item is taken once the run has finished.
module steiner_tree_shortest_path_heuristic_unit import sthr_pkg::*; #(
    parameter int NODE_COUNT  = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    sthr_stream_if.sink   in_ch,
    sthr_stream_if.source out_ch
);

    // command and status between sequencer and datapath
    sthr_cmd_t  cmd;
    sthr_stat_t stat;

    sthr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // tables, masks, link memory and the result register
    sthr_dp #(
        .NODE_COUNT  (NODE_COUNT),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_item    (in_ch.data),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_result (out_ch.data)
    );

endmodule

// ===== sv/sthr_ram.sv =====
// generic single write, single read ram with registered read data
module sthr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sthr_ctrl.sv =====
// sequencer for loads, shortest-path searches and path emission
module sthr_ctrl import sthr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  sthr_stat_t stat,
    output sthr_cmd_t  cmd
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DISPATCH  = 5'd1;
    localparam logic [4:0] S_LD_WR     = 5'd2;
    localparam logic [4:0] S_ROUND     = 5'd3;
    localparam logic [4:0] S_EMIT_IN   = 5'd4;
    localparam logic [4:0] S_T_CHECK   = 5'd5;
    localparam logic [4:0] S_SEL_SCAN  = 5'd6;
    localparam logic [4:0] S_SEL_END   = 5'd7;
    localparam logic [4:0] S_RLX_RD    = 5'd8;
    localparam logic [4:0] S_RLX_WR    = 5'd9;
    localparam logic [4:0] S_DST_SCAN  = 5'd10;
    localparam logic [4:0] S_TRACE     = 5'd11;
    localparam logic [4:0] S_DONE_T    = 5'd12;
    localparam logic [4:0] S_EMIT_PATH = 5'd13;
    localparam logic [4:0] S_EMIT_ERR  = 5'd14;
    localparam logic [4:0] S_SRC_ERR   = 5'd15;

    logic [4:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.mode)
                    MODE_LINK:
                    begin
                        cmd.op     = OP_LD_RD;
                        state_next = S_LD_WR;
                    end
                    MODE_DEST:
                    begin
                        cmd.op     = OP_DEST;
                        state_next = S_IDLE;
                    end
                    MODE_RUN:
                    begin
                        if (stat.src_ok)
                        begin
                            cmd.op     = OP_RUN_INIT;
                            state_next = S_ROUND;
                        end
                        else
                        begin
                            state_next = S_SRC_ERR;
                        end
                    end
                    default:
                    begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LD_WR:
            begin
                cmd.op     = OP_LD_WR;
                state_next = S_IDLE;
            end
            S_ROUND:
            begin
                if (stat.rem_zero)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.inside_nz)
                begin
                    state_next = S_EMIT_IN;
                end
                else
                begin
                    cmd.op     = OP_ROUND_START;
                    state_next = S_T_CHECK;
                end
            end
            S_EMIT_IN:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT_INSIDE;
                    state_next = S_ROUND;
                end
            end
            S_T_CHECK:
            begin
                if (stat.t_end)
                begin
                    state_next = S_DONE_T;
                end
                else if (stat.t_in_tree)
                begin
                    cmd.op     = OP_SRCH_INIT;
                    state_next = S_SEL_SCAN;
                end
                else
                begin
                    cmd.op = OP_T_NEXT;
                end
            end
            S_SEL_SCAN:
            begin
                if (stat.cnt_end)
                begin
                    state_next = S_SEL_END;
                end
                else
                begin
                    cmd.op = OP_SEL_STEP;
                end
            end
            S_SEL_END:
            begin
                if (stat.have)
                begin
                    cmd.op     = OP_SETTLE;
                    state_next = S_RLX_RD;
                end
                else
                begin
                    cmd.op     = OP_DST_START;
                    state_next = S_DST_SCAN;
                end
            end
            S_RLX_RD:
            begin
                state_next = S_RLX_WR;
            end
            S_RLX_WR:
            begin
                cmd.op     = OP_RLX_STEP;
                state_next = stat.cnt_last ? S_SEL_SCAN : S_RLX_RD;
            end
            S_DST_SCAN:
            begin
                if (stat.cnt_end)
                begin
                    cmd.op     = OP_T_NEXT;
                    state_next = S_T_CHECK;
                end
                else if (stat.cand)
                begin
                    cmd.op     = OP_DST_TAKE;
                    state_next = S_TRACE;
                end
                else
                begin
                    cmd.op = OP_DST_SKIP;
                end
            end
            S_TRACE:
            begin
                cmd.op = OP_TRACE_STEP;
                if (stat.trace_stop)
                begin
                    state_next = S_DST_SCAN;
                end
            end
            S_DONE_T:
            begin
                if (stat.found)
                begin
                    cmd.op     = OP_PATH_START;
                    state_next = S_EMIT_PATH;
                end
                else
                begin
                    state_next = S_EMIT_ERR;
                end
            end
            S_EMIT_PATH:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_EMIT_PATH;
                    if (stat.ecnt_one)
                    begin
                        state_next = S_ROUND;
                    end
                end
            end
            S_EMIT_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT_ERR;
                    state_next = S_IDLE;
                end
            end
            S_SRC_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_SRC_ERR;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/sthr_dp.sv =====
// link memory, search tables, tree masks, path buffer and result register
module sthr_dp import sthr_pkg::*; #(
    parameter int NODE_COUNT  = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  sthr_cmd_t    cmd,
    output sthr_stat_t   stat,
    input  sthr_item_t   in_item,
    input  logic         out_ready,
    output logic         out_valid,
    output sthr_result_t out_result
);

    localparam int NB    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CB    = $clog2(NODE_COUNT + 1);
    localparam int AB    = 2 * NB;
    localparam int DEPTH = 1 << AB;
    localparam int DB    = WEIGHT_BITS + 3;
    localparam int WIDE  = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;
    localparam int CW    = (DB > COST_BITS) ? DB : COST_BITS;
    localparam logic [CB-1:0]         CNT_N    = CB'(NODE_COUNT);
    localparam logic [CB-1:0]         CNT_LAST = CB'(NODE_COUNT - 1);
    localparam logic [CB-1:0]         CNT_ONE  = CB'(1);
    localparam logic [NODE_COUNT-1:0] BIT0     = NODE_COUNT'(1);

    function automatic logic [NB-1:0] lowest(input logic [NODE_COUNT-1:0] m);
        logic [NB-1:0] r;
        r = '0;
        for (int i = NODE_COUNT - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                r = NB'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [COST_BITS-1:0] sat_cost(input logic [DB-1:0] c);
        logic [CW-1:0] e;
        e = CW'(c);
        if (e > CW'(COST_MAX))
        begin
            return COST_MAX;
        end
        return e[COST_BITS-1:0];
    endfunction

    // control state
    logic [DEPTH-1:0]      lvalid_reg, lvalid_next;
    logic [NODE_COUNT-1:0] dest_reg, dest_next;
    logic [NODE_COUNT-1:0] tree_reg, tree_next;
    logic [NODE_COUNT-1:0] rem_reg, rem_next;
    logic [NODE_COUNT-1:0] reached_reg, reached_next;
    logic [NODE_COUNT-1:0] settled_reg, settled_next;
    logic [CB-1:0]         t_reg, t_next;
    logic [CB-1:0]         cnt_reg, cnt_next;
    logic [CB-1:0]         plen_reg, plen_next;
    logic [CB-1:0]         ecnt_reg, ecnt_next;
    logic [CB-1:0]         served_reg, served_next;
    logic                  have_reg, have_next;
    logic                  found_reg, found_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    sthr_item_t            item_reg, item_next;
    logic [DB-1:0]         dist_reg [NODE_COUNT];
    logic [DB-1:0]         dist_next [NODE_COUNT];
    logic [NB-1:0]         parent_reg [NODE_COUNT];
    logic [NB-1:0]         parent_next [NODE_COUNT];
    logic [NB-1:0]         path_reg [NODE_COUNT];
    logic [NB-1:0]         path_next [NODE_COUNT];
    logic [NB-1:0]         u_reg, u_next;
    logic [NB-1:0]         cur_reg, cur_next;
    logic [NB-1:0]         best_d_reg, best_d_next;
    logic [DB-1:0]         du_reg, du_next;
    logic [DB-1:0]         best_cost_reg, best_cost_next;
    sthr_result_t          out_reg, out_next;

    logic [NB-1:0]          from_idx, to_idx, cnt_idx, t_idx, par_addr, path_node;
    logic [NB-1:0]          low_tree_dest, low_rem;
    logic                   src_ok, link_ok;
    logic [AB-1:0]          ld_addr, ram_raddr;
    logic [WIDE-1:0]        w_ext;
    logic [WEIGHT_BITS-1:0] w_sat, ram_rdata;
    logic                   ram_we;
    logic [DB-1:0]          dist_rd, nd;
    logic [NB-1:0]          par_rd;
    logic [NODE_COUNT-1:0]  tree_dests;
    logic [CB-1:0]          ecnt_m1;
    logic [3:0]             served4;
    logic                   cand;

    assign from_idx = item_reg.from_node[NB-1:0];
    assign to_idx   = item_reg.to_node[NB-1:0];
    assign src_ok   = {1'b0, item_reg.from_node} < 4'(NODE_COUNT);
    assign link_ok  = src_ok && ({1'b0, item_reg.to_node} < 4'(NODE_COUNT));
    assign ld_addr  = {from_idx, to_idx};
    assign cnt_idx  = cnt_reg[NB-1:0];
    assign t_idx    = t_reg[NB-1:0];

    // weights beyond the stored range saturate
    assign w_ext = WIDE'(item_reg.link_weight);
    assign w_sat = (w_ext > WIDE'({WEIGHT_BITS{1'b1}})) ? {WEIGHT_BITS{1'b1}}
                                                         : w_ext[WEIGHT_BITS-1:0];

    assign ram_raddr = (cmd.op == OP_LD_RD) ? ld_addr : {u_reg, cnt_idx};
    assign ram_we    = (cmd.op == OP_LD_WR) && link_ok &&
                       (!lvalid_reg[ld_addr] || (w_sat < ram_rdata));

    sthr_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ld_addr),
        .wdata (w_sat),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign dist_rd       = dist_reg[cnt_idx];
    assign par_addr      = (cmd.op == OP_TRACE_STEP) ? cur_reg : cnt_idx;
    assign par_rd        = parent_reg[par_addr];
    assign nd            = du_reg + DB'(ram_rdata);
    assign tree_dests    = rem_reg & tree_reg;
    assign low_tree_dest = lowest(tree_dests);
    assign low_rem       = lowest(rem_reg);
    assign ecnt_m1       = ecnt_reg - CNT_ONE;
    assign path_node     = path_reg[ecnt_m1[NB-1:0]];
    assign served4       = 4'(served_reg);
    assign cand          = rem_reg[cnt_idx] && reached_reg[cnt_idx] &&
                           (!found_reg || (dist_rd < best_cost_reg));

    always_comb
    begin
        lvalid_next    = lvalid_reg;
        dest_next      = dest_reg;
        tree_next      = tree_reg;
        rem_next       = rem_reg;
        reached_next   = reached_reg;
        settled_next   = settled_reg;
        t_next         = t_reg;
        cnt_next       = cnt_reg;
        plen_next      = plen_reg;
        ecnt_next      = ecnt_reg;
        served_next    = served_reg;
        have_next      = have_reg;
        found_next     = found_reg;
        item_next      = item_reg;
        dist_next      = dist_reg;
        parent_next    = parent_reg;
        path_next      = path_reg;
        u_next         = u_reg;
        cur_next       = cur_reg;
        best_d_next    = best_d_reg;
        du_next        = du_reg;
        best_cost_next = best_cost_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (cmd.op)
            OP_ACCEPT:
            begin
                item_next = in_item;
            end
            OP_DEST:
            begin
                if ({1'b0, item_reg.to_node} < 4'(NODE_COUNT))
                begin
                    dest_next = dest_reg | (BIT0 << to_idx);
                end
            end
            OP_CLEAR:
            begin
                lvalid_next = '0;
                dest_next   = '0;
                tree_next   = '0;
            end
            OP_LD_WR:
            begin
                if (ram_we)
                begin
                    lvalid_next[ld_addr] = 1'b1;
                end
            end
            OP_RUN_INIT:
            begin
                tree_next   = BIT0 << from_idx;
                rem_next    = dest_reg;
                served_next = '0;
            end
            OP_ROUND_START:
            begin
                t_next     = '0;
                found_next = 1'b0;
            end
            OP_EMIT_INSIDE:
            begin
                out_next.path_index  = served4[2:0];
                out_next.node        = 3'(low_tree_dest);
                out_next.path_cost   = '0;
                out_next.end_of_path = 1'b1;
                out_next.last        = ((rem_reg & ~(BIT0 << low_tree_dest)) == '0);
                out_next.status      = STATUS_OK;
                out_valid_next       = 1'b1;
                rem_next             = rem_reg & ~(BIT0 << low_tree_dest);
                served_next          = served_reg + CNT_ONE;
            end
            OP_T_NEXT:
            begin
                t_next = t_reg + CNT_ONE;
            end
            OP_SRCH_INIT:
            begin
                dist_next[t_idx]   = '0;
                parent_next[t_idx] = t_idx;
                reached_next       = BIT0 << t_idx;
                settled_next       = '0;
                cnt_next           = '0;
                have_next          = 1'b0;
            end
            OP_SEL_STEP:
            begin
                if (reached_reg[cnt_idx] && !settled_reg[cnt_idx] &&
                    (!have_reg || (dist_rd < du_reg)))
                begin
                    have_next = 1'b1;
                    u_next    = cnt_idx;
                    du_next   = dist_rd;
                end
                cnt_next = cnt_reg + CNT_ONE;
            end
            OP_SETTLE:
            begin
                settled_next = settled_reg | (BIT0 << u_reg);
                cnt_next     = '0;
            end
            OP_RLX_STEP:
            begin
                if (!settled_reg[cnt_idx] && lvalid_reg[{u_reg, cnt_idx}])
                begin
                    if (!reached_reg[cnt_idx] || (nd < dist_rd))
                    begin
                        reached_next[cnt_idx] = 1'b1;
                        dist_next[cnt_idx]    = nd;
                        parent_next[cnt_idx]  = u_reg;
                    end
                    else if ((nd == dist_rd) && (u_reg < par_rd))
                    begin
                        parent_next[cnt_idx] = u_reg;
                    end
                end
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next  = '0;
                    have_next = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_ONE;
                end
            end
            OP_DST_START:
            begin
                cnt_next = '0;
            end
            OP_DST_SKIP:
            begin
                cnt_next = cnt_reg + CNT_ONE;
            end
            OP_DST_TAKE:
            begin
                found_next     = 1'b1;
                best_cost_next = dist_rd;
                best_d_next    = cnt_idx;
                plen_next      = '0;
                cur_next       = cnt_idx;
            end
            OP_TRACE_STEP:
            begin
                // path is built destination first, walked back through parents
                path_next[plen_reg[NB-1:0]] = cur_reg;
                plen_next                   = plen_reg + CNT_ONE;
                cur_next                    = par_rd;
                if ((cur_reg == t_idx) || (plen_reg == CNT_LAST))
                begin
                    cnt_next = cnt_reg + CNT_ONE;
                end
            end
            OP_PATH_START:
            begin
                ecnt_next = plen_reg;
            end
            OP_EMIT_PATH:
            begin
                out_next.path_index  = served4[2:0];
                out_next.node        = 3'(path_node);
                out_next.path_cost   = sat_cost(best_cost_reg);
                out_next.end_of_path = (ecnt_reg == CNT_ONE);
                out_next.last        = (ecnt_reg == CNT_ONE) &&
                                       ((rem_reg & ~(BIT0 << best_d_reg)) == '0);
                out_next.status      = STATUS_OK;
                out_valid_next       = 1'b1;
                tree_next            = tree_reg | (BIT0 << path_node);
                ecnt_next            = ecnt_m1;
                if (ecnt_reg == CNT_ONE)
                begin
                    rem_next    = rem_reg & ~(BIT0 << best_d_reg);
                    served_next = served_reg + CNT_ONE;
                end
            end
            OP_EMIT_ERR:
            begin
                out_next.path_index  = served4[2:0];
                out_next.node        = 3'(low_rem);
                out_next.path_cost   = '0;
                out_next.end_of_path = 1'b0;
                out_next.last        = 1'b1;
                out_next.status      = STATUS_UNRCH;
                out_valid_next       = 1'b1;
            end
            OP_SRC_ERR:
            begin
                out_next.path_index  = '0;
                out_next.node        = item_reg.from_node;
                out_next.path_cost   = '0;
                out_next.end_of_path = 1'b0;
                out_next.last        = 1'b1;
                out_next.status      = STATUS_UNRCH;
                out_valid_next       = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvalid_reg    <= '0;
            dest_reg      <= '0;
            tree_reg      <= '0;
            rem_reg       <= '0;
            reached_reg   <= '0;
            settled_reg   <= '0;
            t_reg         <= '0;
            cnt_reg       <= '0;
            plen_reg      <= '0;
            ecnt_reg      <= '0;
            served_reg    <= '0;
            have_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lvalid_reg    <= lvalid_next;
            dest_reg      <= dest_next;
            tree_reg      <= tree_next;
            rem_reg       <= rem_next;
            reached_reg   <= reached_next;
            settled_reg   <= settled_next;
            t_reg         <= t_next;
            cnt_reg       <= cnt_next;
            plen_reg      <= plen_next;
            ecnt_reg      <= ecnt_next;
            served_reg    <= served_next;
            have_reg      <= have_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        dist_reg      <= dist_next;
        parent_reg    <= parent_next;
        path_reg      <= path_next;
        u_reg         <= u_next;
        cur_reg       <= cur_next;
        best_d_reg    <= best_d_next;
        du_reg        <= du_next;
        best_cost_reg <= best_cost_next;
        out_reg       <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    always_comb
    begin
        stat.mode       = item_reg.mode;
        stat.src_ok     = src_ok;
        stat.rem_zero   = (rem_reg == '0);
        stat.inside_nz  = (tree_dests != '0);
        stat.t_end      = (t_reg == CNT_N);
        stat.t_in_tree  = tree_reg[t_idx];
        stat.cnt_end    = (cnt_reg == CNT_N);
        stat.cnt_last   = (cnt_reg == CNT_LAST);
        stat.have       = have_reg;
        stat.cand       = cand;
        stat.trace_stop = (cur_reg == t_idx) || (plen_reg == CNT_LAST);
        stat.found      = found_reg;
        stat.ecnt_one   = (ecnt_reg == CNT_ONE);
        stat.out_free   = !out_valid_reg || out_ready;
    end

endmodule

// ===== tb/sv/tb_sthr_types.sv =====
`timescale 1ns / 100ps
// stimulus row and expected-result record types of the steiner tree testbench
package tb_sthr_types;
    import sthr_pkg::*;

    typedef struct {
        sthr_item_t   item;
        bit           has_known;
        sthr_result_t known;
    } stim_row_t;
endpackage

// ===== tb/sv/tb_steiner_tree_shortest_path_heuristic_unit.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the shortest-path heuristic multicast tree builder
module tb_steiner_tree_shortest_path_heuristic_unit;
    import sthr_pkg::*;
    import tb_sthr_types::*;

    localparam int NODES      = 8;
    localparam int WBITS      = 16;
    // idle-cycle limit: must exceed the worst run plus output stalls
    localparam int IDLE_LIMIT = 200000;

    logic clk;
    logic rst_n;

    sthr_stream_if #(.payload_t(sthr_item_t))   in_ch ();
    sthr_stream_if #(.payload_t(sthr_result_t)) out_ch ();

    steiner_tree_shortest_path_heuristic_unit #(
        .NODE_COUNT  (NODES),
        .WEIGHT_BITS (WBITS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // predictor state: graph, destination set, tree
    logic [WBITS-1:0] link_w [NODES*NODES];
    bit               link_ok [NODES*NODES];
    logic [NODES-1:0] dest_set;
    logic [NODES-1:0] tree_set;
    logic [19:0]      dist_tab [NODES];
    logic [2:0]       par [NODES];

    sthr_result_t expected_paths[$];
    int           error_count;
    bit           quiet_phase;
    int           idle_cycles;

    always #5 clk = ~clk;

    // shortest-path search from one tree node; returns the reached set
    function automatic logic [NODES-1:0] search_tree_node(input int src);
        logic [NODES-1:0] reached;
        logic [NODES-1:0] settled;
        logic [19:0]      nd;
        int               u;
        reached   = '0;
        settled   = '0;
        reached[src] = 1'b1;
        dist_tab[src] = '0;
        par[src]  = src[2:0];
        forever
        begin
            u = NODES;
            for (int i = 0; i < NODES; i++)
            begin
                if (reached[i] && !settled[i] && (u == NODES || dist_tab[i] < dist_tab[u]))
                    u = i;
            end
            if (u == NODES)
                break;
            settled[u] = 1'b1;
            for (int v = 0; v < NODES; v++)
            begin
                if (settled[v] || !link_ok[u*NODES+v])
                    continue;
                nd = dist_tab[u] + link_w[u*NODES+v];
                if (!reached[v] || nd < dist_tab[v])
                begin
                    reached[v]  = 1'b1;
                    dist_tab[v] = nd;
                    par[v]      = u[2:0];
                end
                else if (nd == dist_tab[v] && u < par[v])
                    par[v] = u[2:0];
            end
        end
        return reached;
    endfunction

    function automatic sthr_result_t make_path_node(int idx, int nd, logic [19:0] cost,
                                                    bit eop, bit st);
        sthr_result_t r;
        r.path_index  = idx[2:0];
        r.node        = nd[2:0];
        r.path_cost   = (cost > COST_MAX) ? COST_MAX : cost[18:0];
        r.end_of_path = eop;
        r.last        = 1'b0;
        r.status      = st;
        return r;
    endfunction

    function automatic int lowest_node(logic [NODES-1:0] m);
        for (int i = 0; i < NODES; i++)
            if (m[i])
                return i;
        return NODES;
    endfunction

    // apply one item to the predictor, queueing the path nodes it produces
    task automatic predict_tree(input sthr_item_t it);
        sthr_result_t     run_out[$];
        logic [NODES-1:0] remaining, on_tree, reached;
        logic [19:0]      best_cost;
        int               best_d, plen, cur, served;
        int               path[NODES];
        bit               found;
        served = 0;
        case (it.mode)
            MODE_LINK:
            begin
                if (!link_ok[it.from_node*NODES+it.to_node] ||
                    it.link_weight < link_w[it.from_node*NODES+it.to_node])
                begin
                    link_ok[it.from_node*NODES+it.to_node] = 1'b1;
                    link_w[it.from_node*NODES+it.to_node]  = it.link_weight;
                end
            end
            MODE_DEST:
                dest_set[it.to_node] = 1'b1;
            MODE_CLEAR:
            begin
                foreach (link_ok[i])
                    link_ok[i] = 1'b0;
                dest_set = '0;
                tree_set = '0;
            end
            default:
            begin
                tree_set  = '0;
                tree_set[it.from_node] = 1'b1;
                remaining = dest_set;
                while (remaining != '0)
                begin
                    on_tree = remaining & tree_set;
                    if (on_tree != '0)
                    begin
                        // destination already on the tree: one-node path, zero cost
                        best_d = lowest_node(on_tree);
                        run_out = {run_out,
                                   make_path_node(served, best_d, 0, 1'b1, STATUS_OK)};
                        remaining[best_d] = 1'b0;
                        served++;
                        continue;
                    end
                    found = 1'b0;
                    best_cost = '0;
                    best_d = 0;
                    plen = 0;
                    for (int t = 0; t < NODES; t++)
                    begin
                        if (!tree_set[t])
                            continue;
                        reached = search_tree_node(t);
                        for (int d = 0; d < NODES; d++)
                        begin
                            if (!(remaining[d] && reached[d]))
                                continue;
                            if (found && dist_tab[d] >= best_cost)
                                continue;
                            found = 1'b1;
                            best_cost = dist_tab[d];
                            best_d = d;
                            plen = 0;
                            cur = d;
                            while (plen < NODES)
                            begin
                                path[plen++] = cur;
                                if (cur == t)
                                    break;
                                cur = par[cur];
                            end
                        end
                    end
                    if (!found)
                    begin
                        // unreachable destination aborts the run
                        run_out = {run_out,
                                   make_path_node(served, lowest_node(remaining), 0,
                                                  1'b0, STATUS_UNRCH)};
                        break;
                    end
                    for (int i = plen; i > 0; i--)
                    begin
                        tree_set[path[i-1]] = 1'b1;
                        run_out = {run_out,
                                   make_path_node(served, path[i-1], best_cost,
                                                  i == 1, STATUS_OK)};
                    end
                    remaining[best_d] = 1'b0;
                    served++;
                end
                if (run_out.size() > 0)
                    run_out[$].last = 1'b1;
                expected_paths = {expected_paths, run_out};
            end
        endcase
    endtask

    // send one item, waiting for its transfer, with random idle bursts
    task automatic send_item(input sthr_item_t it);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_tree(it);
    endtask

    function automatic sthr_item_t mk(logic [1:0] m, int f, int t, int w);
        sthr_item_t it;
        it.mode = m;
        it.from_node = f[2:0];
        it.to_node = t[2:0];
        it.link_weight = w[15:0];
        return it;
    endfunction

    // receiver: random stall bursts, field-by-field compare
    initial
    begin
        sthr_result_t exp_r;
        sthr_result_t got;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                if (expected_paths.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %p", $realtime, got);
                    error_count++;
                end
                else
                begin
                    exp_r = expected_paths.pop_front();
                    if (got.path_index !== exp_r.path_index || got.node !== exp_r.node ||
                        got.path_cost !== exp_r.path_cost ||
                        got.end_of_path !== exp_r.end_of_path ||
                        got.last !== exp_r.last || got.status !== exp_r.status)
                    begin
                        $display("%0t mismatch: expected %p, actual %p", $realtime, exp_r, got);
                        error_count++;
                    end
                end
            end
            if (!quiet_phase && out_ch.ready && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   rows[$];
        stim_row_t   row;
        sthr_item_t  it;
        sthr_result_t r;
        int          pick, nn;
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        error_count = 0;
        quiet_phase = 1'b0;
        idle_cycles = 0;
        dest_set = '0;
        tree_set = '0;
        foreach (link_ok[i])
        begin
            link_ok[i] = 1'b0;
            link_w[i]  = '0;
        end

        // directed table; known results only for obvious rows
        row.has_known = 1'b0;
        row.known = '0;
        row.item = mk(MODE_RUN, 3, 0, 0);              // empty set after reset
        rows = {rows, row};
        row.item = mk(MODE_DEST, 0, 5, 0);
        rows = {rows, row};
        row.item = mk(MODE_RUN, 2, 0, 0);              // no links: unreachable
        row.has_known = 1'b1;
        row.known = '{path_index: 0, node: 5, path_cost: 0, end_of_path: 0,
                      last: 1, status: STATUS_UNRCH};
        rows = {rows, row};
        row.has_known = 1'b0;
        row.item = mk(MODE_RUN, 5, 0, 0);              // source is the destination
        row.has_known = 1'b1;
        row.known = '{path_index: 0, node: 5, path_cost: 0, end_of_path: 1,
                      last: 1, status: STATUS_OK};
        rows = {rows, row};
        row.has_known = 1'b0;
        row.item = mk(MODE_LINK, 0, 1, 65535); rows = {rows, row};
        row.item = mk(MODE_LINK, 1, 2, 65535); rows = {rows, row};
        row.item = mk(MODE_LINK, 2, 3, 65535); rows = {rows, row};
        row.item = mk(MODE_LINK, 3, 4, 65535); rows = {rows, row};
        row.item = mk(MODE_LINK, 4, 5, 65535); rows = {rows, row};
        row.item = mk(MODE_LINK, 5, 6, 65535); rows = {rows, row};
        row.item = mk(MODE_LINK, 6, 7, 65535); rows = {rows, row};
        row.item = mk(MODE_DEST, 0, 7, 0);   rows = {rows, row};
        row.item = mk(MODE_RUN, 0, 0, 0);    rows = {rows, row};   // long chain, large cost
        row.item = mk(MODE_LINK, 0, 7, 0);   rows = {rows, row};   // zero weight
        row.item = mk(MODE_LINK, 0, 7, 9);   rows = {rows, row};   // repeat keeps min
        row.item = mk(MODE_LINK, 0, 2, 3);   rows = {rows, row};   // equal-distance ties
        row.item = mk(MODE_LINK, 1, 2, 1);   rows = {rows, row};
        row.item = mk(MODE_LINK, 0, 1, 2);   rows = {rows, row};
        row.item = mk(MODE_DEST, 0, 2, 0);   rows = {rows, row};
        row.item = mk(MODE_RUN, 0, 0, 0);    rows = {rows, row};
        row.item = mk(MODE_RUN, 7, 0, 0);    rows = {rows, row};
        row.item = mk(MODE_CLEAR, 7, 7, 65535);
        rows = {rows, row};
        row.item = mk(MODE_RUN, 0, 0, 0);    rows = {rows, row};   // cleared: no results

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_item(rows[i].item);
            if (rows[i].has_known)
            begin
                // compare the prediction with the hand-written value
                r = expected_paths[$];
                if (r !== rows[i].known)
                begin
                    $display("%0t predictor disagrees: expected %p, actual %p",
                             $realtime, rows[i].known, r);
                    error_count++;
                end
            end
        end

        // random part: build small graphs, add destinations, run; some noise
        for (int n = 0; n < 300; n++)
        begin
            if (n > 260)
                quiet_phase = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                nn = $urandom_range(0, 3);
                it = mk(MODE_LINK, $urandom_range(0, 7), $urandom_range(0, 7),
                        nn == 0 ? $urandom() : (nn == 1 ? 16'hFFFF - $urandom_range(0, 3)
                                                        : $urandom_range(0, 40)));
            end
            else if (pick < 68)
                it = mk(MODE_DEST, $urandom(), $urandom_range(0, 7), $urandom());
            else if (pick < 95)
                it = mk(MODE_RUN, $urandom_range(0, 7), $urandom(), $urandom());
            else
                it = mk(MODE_CLEAR, $urandom(), $urandom(), $urandom());
            send_item(it);
        end
        in_ch.valid <= 1'b0;

        wait (expected_paths.size() == 0);
        repeat (20000) @(posedge clk);
        if (error_count == 0 && expected_paths.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== steiner_tree_shortest_path_heuristic_unit.f =====
sv/sthr_pkg.sv
sv/sthr_stream_if.sv
sv/sthr_ram.sv
sv/sthr_ctrl.sv
sv/sthr_dp.sv
sv/steiner_tree_shortest_path_heuristic_unit.sv
tb/sv/tb_sthr_types.sv
tb/sv/tb_steiner_tree_shortest_path_heuristic_unit.sv
